@@ src/ebpc_pkg.sv @@
// shared types and constants for the encoder button pulse commander
`timescale 1ns / 1ps

package ebpc_pkg;

   // configuration register indexes
   localparam int CsrIndexWidth = 3;
   localparam logic [CsrIndexWidth-1:0] CSR_PULSE_TICKS    = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_GAP_TICKS      = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_ENC_DEBOUNCE   = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_BTN_DEBOUNCE   = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_IDLE_POSITION  = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_UP_POSITION    = 3'd5;
   localparam logic [CsrIndexWidth-1:0] CSR_DOWN_POSITION  = 3'd6;
   localparam logic [CsrIndexWidth-1:0] CSR_MUTE_POSITION  = 3'd7;

   localparam int CsrDataWidth = 16;
   localparam int CountWidth   = 16;
   localparam int AgeWidth     = 8;
   localparam int PosWidth     = 8;

   // register reset values
   localparam logic [CountWidth-1:0] PULSE_TICKS_RESET = 16'd50;
   localparam logic [7:0] GAP_TICKS_RESET     = 8'd10;
   localparam logic [7:0] ENC_DEBOUNCE_RESET  = 8'd5;
   localparam logic [7:0] BTN_DEBOUNCE_RESET  = 8'd50;
   localparam logic [7:0] IDLE_POSITION_RESET = 8'd255;
   localparam logic [7:0] UP_POSITION_RESET   = 8'd41;
   localparam logic [7:0] DOWN_POSITION_RESET = 8'd61;
   localparam logic [7:0] MUTE_POSITION_RESET = 8'd9;

   localparam logic [AgeWidth-1:0] AGE_MAX = 8'd255;

   typedef enum logic [1:0] {
      KIND_UP      = 2'd0,
      KIND_DOWN    = 2'd1,
      KIND_MUTE    = 2'd2,
      KIND_RELEASE = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      PHASE_IDLE = 2'd0,
      PHASE_HOLD = 2'd1,
      PHASE_GAP  = 2'd2
   } phase_type;

   typedef struct packed {
      logic [CountWidth-1:0] pulse_ticks;
      logic [7:0]            gap_ticks;
      logic [7:0]            encoder_debounce_ticks;
      logic [7:0]            button_debounce_ticks;
      logic [PosWidth-1:0]   idle_position;
      logic [PosWidth-1:0]   up_position;
      logic [PosWidth-1:0]   down_position;
      logic [PosWidth-1:0]   mute_position;
   } cfg_type;

   typedef struct packed {
      logic step_up;
      logic step_down;
   } step_type;

   typedef struct packed {
      logic                emit;
      logic [PosWidth-1:0] wiper_value;
      kind_type            command_kind;
   } result_type;

endpackage

@@ src/ebpc_encoder.sv @@
// encoder line a debounce and step direction decode
`timescale 1ns / 1ps

module ebpc_encoder import ebpc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          fire,
   input  logic          line_a,
   input  logic          line_b,
   input  logic [7:0]    debounce_ticks,
   output step_type      step
);

   logic                prev_raw_a_ff, prev_raw_a_in;
   logic                accepted_a_ff, accepted_a_in;
   logic [AgeWidth-1:0] age_ff, age_in;
   logic [AgeWidth-1:0] age_inc;
   logic                edge_ok;

   // age since last accepted edge, saturating
   always_comb begin
      age_inc = (age_ff != AGE_MAX) ? age_ff + 1'b1 : age_ff;
      edge_ok = (line_a != prev_raw_a_ff) && (age_inc >= debounce_ticks);
      prev_raw_a_in = line_a;
      accepted_a_in = accepted_a_ff;
      age_in = age_inc;
      step = '0;
      if (edge_ok) begin
         age_in = '0;
         if (line_a != accepted_a_ff) begin
            accepted_a_in = line_a;
            step.step_up = (line_b != line_a);
            step.step_down = (line_b == line_a);
         end
      end
      if (!fire) begin
         step = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_raw_a_ff <= 1'b1;
         accepted_a_ff <= 1'b1;
         age_ff <= AGE_MAX;
      end else if (fire) begin
         prev_raw_a_ff <= prev_raw_a_in;
         accepted_a_ff <= accepted_a_in;
         age_ff <= age_in;
      end
   end

endmodule

@@ src/ebpc_button.sv @@
// mute button stability timer and request flag
`timescale 1ns / 1ps

module ebpc_button import ebpc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  logic       button_level,
   input  logic [7:0] debounce_ticks,
   input  logic       mute_taken,
   output logic       mute_req
);

   logic                prev_button_ff, prev_button_in;
   logic [AgeWidth-1:0] age_ff, age_in;
   logic                handled_ff, handled_in;

   // level change restarts the timer and rearms the request
   always_comb begin
      prev_button_in = button_level;
      age_in = (age_ff != AGE_MAX) ? age_ff + 1'b1 : age_ff;
      handled_in = handled_ff;
      if (button_level != prev_button_ff) begin
         age_in = '0;
         handled_in = 1'b0;
      end
      mute_req = fire && (age_in > debounce_ticks) && !button_level && !handled_in;
      if (mute_taken) begin
         handled_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_button_ff <= 1'b1;
         age_ff <= '0;
         handled_ff <= 1'b0;
      end else if (fire) begin
         prev_button_ff <= prev_button_in;
         age_ff <= age_in;
         handled_ff <= handled_in;
      end
   end

endmodule

@@ src/ebpc_sequencer.sv @@
// step accumulator and wiper pulse sequencer
`timescale 1ns / 1ps

module ebpc_sequencer import ebpc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  cfg_type    cfg,
   input  step_type   step,
   input  logic       mute_req,
   output logic       mute_taken,
   output result_type result
);

   logic signed [7:0]     acc_ff, acc_in, acc_stepped;
   phase_type             phase_ff, phase_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [CountWidth-1:0] gap_count;
   logic                  go_idle;

   // saturating accumulator step
   always_comb begin
      acc_stepped = acc_ff;
      if (step.step_up && (acc_ff != 8'sd127)) begin
         acc_stepped = acc_ff + 8'sd1;
      end else if (step.step_down && (acc_ff != -8'sd128)) begin
         acc_stepped = acc_ff - 8'sd1;
      end
   end

   assign gap_count = (count_ff != '0) ? count_ff - 1'b1 : count_ff;

   // next phase and counter
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      go_idle = 1'b0;
      unique case (phase_ff)
         PHASE_HOLD: begin
            if (count_ff <= 16'd1) begin
               phase_in = PHASE_GAP;
               count_in = {{(CountWidth-8){1'b0}}, cfg.gap_ticks};
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         PHASE_GAP: begin
            count_in = gap_count;
            if (gap_count == '0) begin
               go_idle = 1'b1;
            end
         end
         default: begin
            go_idle = 1'b1;
         end
      endcase
      if (go_idle) begin
         phase_in = PHASE_IDLE;
         if ((acc_stepped != 8'sd0) || mute_req) begin
            phase_in = PHASE_HOLD;
            count_in = cfg.pulse_ticks;
         end
      end
   end

   // result, accumulator clear and mute handshake
   always_comb begin
      result = '0;
      result.command_kind = KIND_RELEASE;
      acc_in = acc_stepped;
      mute_take_blk: begin
         mute_taken = 1'b0;
      end
      if (phase_ff == PHASE_HOLD) begin
         if (count_ff <= 16'd1) begin
            result.emit = 1'b1;
            result.wiper_value = cfg.idle_position;
            result.command_kind = KIND_RELEASE;
         end
      end else if (go_idle) begin
         if (acc_stepped != 8'sd0) begin
            acc_in = '0;
            result.emit = 1'b1;
            if (!acc_stepped[7]) begin
               result.wiper_value = cfg.up_position;
               result.command_kind = KIND_UP;
            end else begin
               result.wiper_value = cfg.down_position;
               result.command_kind = KIND_DOWN;
            end
         end else if (mute_req) begin
            mute_taken = 1'b1;
            result.emit = 1'b1;
            result.wiper_value = cfg.mute_position;
            result.command_kind = KIND_MUTE;
         end
      end
      if (!fire) begin
         result.emit = 1'b0;
         mute_taken = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         phase_ff <= PHASE_IDLE;
         count_ff <= '0;
      end else if (fire) begin
         acc_ff <= acc_in;
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

endmodule

@@ src/encoder_button_pulse_commander.sv @@
// a tick item accepted into the input register loads its result into the result register
// once it fires, which result channel backpressure can hold off (input and result register)
// throughput: one tick item per cycle, limited only by result channel backpressure
// a tick that causes no result still takes one pass through the input register
// reset: synchronous, active high; clears both stages, all tracking state and
// restores every configuration register to its default
`timescale 1ns / 1ps

module encoder_button_pulse_commander import ebpc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_line_a,
   input  logic                     req_line_b,
   input  logic                     req_button_level,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [PosWidth-1:0]      rsp_wiper_value,
   output logic [1:0]               rsp_command_kind,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata
);

   cfg_type             cfg_ff;
   logic                in_valid_ff;
   logic                in_a_ff, in_b_ff, in_btn_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PosWidth-1:0] rsp_wiper_ff;
   kind_type            rsp_kind_ff;
   logic                fire;
   step_type            step;
   logic                mute_req;
   logic                mute_taken;
   result_type          result;

   // item in the input register is processed when the result register has room
   assign fire = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulse_ticks <= PULSE_TICKS_RESET;
         cfg_ff.gap_ticks <= GAP_TICKS_RESET;
         cfg_ff.encoder_debounce_ticks <= ENC_DEBOUNCE_RESET;
         cfg_ff.button_debounce_ticks <= BTN_DEBOUNCE_RESET;
         cfg_ff.idle_position <= IDLE_POSITION_RESET;
         cfg_ff.up_position <= UP_POSITION_RESET;
         cfg_ff.down_position <= DOWN_POSITION_RESET;
         cfg_ff.mute_position <= MUTE_POSITION_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PULSE_TICKS:   cfg_ff.pulse_ticks <= csr_wdata;
            CSR_GAP_TICKS:     cfg_ff.gap_ticks <= csr_wdata[7:0];
            CSR_ENC_DEBOUNCE:  cfg_ff.encoder_debounce_ticks <= csr_wdata[7:0];
            CSR_BTN_DEBOUNCE:  cfg_ff.button_debounce_ticks <= csr_wdata[7:0];
            CSR_IDLE_POSITION: cfg_ff.idle_position <= csr_wdata[7:0];
            CSR_UP_POSITION:   cfg_ff.up_position <= csr_wdata[7:0];
            CSR_DOWN_POSITION: cfg_ff.down_position <= csr_wdata[7:0];
            CSR_MUTE_POSITION: cfg_ff.mute_position <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_a_ff <= req_line_a;
         in_b_ff <= req_line_b;
         in_btn_ff <= req_button_level;
      end
   end

   ebpc_encoder u_encoder (
      .clock          (clock),
      .reset          (reset),
      .fire           (fire),
      .line_a         (in_a_ff),
      .line_b         (in_b_ff),
      .debounce_ticks (cfg_ff.encoder_debounce_ticks),
      .step           (step)
   );

   ebpc_button u_button (
      .clock          (clock),
      .reset          (reset),
      .fire           (fire),
      .button_level   (in_btn_ff),
      .debounce_ticks (cfg_ff.button_debounce_ticks),
      .mute_taken     (mute_taken),
      .mute_req       (mute_req)
   );

   ebpc_sequencer u_sequencer (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .cfg        (cfg_ff),
      .step       (step),
      .mute_req   (mute_req),
      .mute_taken (mute_taken),
      .result     (result)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (result.emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.emit) begin
         rsp_wiper_ff <= result.wiper_value;
         rsp_kind_ff <= result.command_kind;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_wiper_value = rsp_wiper_ff;
   assign rsp_command_kind = rsp_kind_ff;

endmodule

@@ src/ebpc_checker.sv @@
// port level checks for the encoder button pulse commander, bound to the top level
`timescale 1ns / 1ps

module ebpc_checker import ebpc_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [PosWidth-1:0]      rsp_wiper_value,
   input logic [1:0]               rsp_command_kind
);

   logic last_release_ff;
   logic rsp_xfer;

   assign rsp_xfer = rsp_valid && rsp_ready;

   // kind of the last result transfer: command or release
   always_ff @(posedge clock) begin
      if (reset) begin
         last_release_ff <= 1'b1;
      end else if (rsp_xfer) begin
         last_release_ff <= (rsp_command_kind == KIND_RELEASE);
      end
   end

   // commands and releases alternate, starting with a command
   assert property (@(posedge clock) disable iff (reset)
      rsp_xfer |-> ((rsp_command_kind == KIND_RELEASE) != last_release_ff))
      else $error("command and release transfers out of order");

   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a fresh result needs an earlier input transfer
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result appeared without an input transfer");

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_wiper_value) && $stable(rsp_command_kind))
      else $error("stalled result changed");

endmodule

bind encoder_button_pulse_commander ebpc_checker u_ebpc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_wiper_value  (rsp_wiper_value),
   .rsp_command_kind (rsp_command_kind)
);

@@ bench/tb_encoder_button_pulse_commander.sv @@
// self-checking testbench for the encoder button pulse commander
`timescale 1ns / 1ps

module tb_encoder_button_pulse_commander;
   import ebpc_pkg::*;

   localparam int IDLE_PERCENT  = 9;
   localparam int SETTLE_CYCLES = 6;
   localparam int STALL_CYCLES  = 300;
   localparam int LIMIT_CYCLES  = 400000;
   localparam logic signed [7:0] STEP_MAX = 8'sh7f;
   localparam logic signed [7:0] STEP_MIN = 8'sh80;

   typedef struct packed {
      logic a;
      logic b;
      logic button;
   } tick_sample_type;

   typedef struct packed {
      logic [PosWidth-1:0] wiper;
      kind_type            kind;
   } wiper_write_type;

   logic                     clock;
   logic                     reset            = 1'b1;
   logic                     req_valid        = 1'b0;
   logic                     req_ready;
   logic                     req_line_a       = 1'b1;
   logic                     req_line_b       = 1'b1;
   logic                     req_button_level = 1'b1;
   logic                     rsp_valid;
   logic                     rsp_ready        = 1'b0;
   logic [PosWidth-1:0]      rsp_wiper_value;
   logic [1:0]               rsp_command_kind;
   logic                     csr_valid        = 1'b0;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index        = CSR_PULSE_TICKS;
   logic [CsrDataWidth-1:0]  csr_wdata        = '0;

   // pending tick samples and the wiper writes they are predicted to cause
   tick_sample_type tick_queue[$];
   wiper_write_type expected_writes[$];

   int error_count    = 0;
   int cycle_count    = 0;
   int stall_left     = 0;
   bit stall_done     = 1'b0;
   bit steady_run     = 1'b0;

   // line levels at the tail of the queued stimulus
   logic line_a_now = 1'b1;
   logic line_b_now = 1'b1;
   logic button_now = 1'b1;

   // predictor copy of the configuration and tracking state
   cfg_type cfg = '{PULSE_TICKS_RESET, GAP_TICKS_RESET, ENC_DEBOUNCE_RESET,
                    BTN_DEBOUNCE_RESET, IDLE_POSITION_RESET, UP_POSITION_RESET,
                    DOWN_POSITION_RESET, MUTE_POSITION_RESET};
   logic                  raw_a       = 1'b1;
   logic                  settled_a   = 1'b1;
   logic [AgeWidth-1:0]   enc_age     = AGE_MAX;
   logic signed [7:0]     step_count  = '0;
   logic                  last_button = 1'b1;
   logic [AgeWidth-1:0]   button_age  = '0;
   logic                  button_done = 1'b0;
   phase_type             phase       = PHASE_IDLE;
   logic [CountWidth-1:0] phase_count = '0;

   encoder_button_pulse_commander uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_line_a       (req_line_a),
      .req_line_b       (req_line_b),
      .req_button_level (req_button_level),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_wiper_value  (rsp_wiper_value),
      .rsp_command_kind (rsp_command_kind),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // one tick of the commander: encoder, then button, then sequencer
   function automatic void advance_commander(input logic a, input logic b,
                                             input logic button, output logic fired,
                                             output wiper_write_type cmd);
      logic mute_wanted;
      fired = 1'b0;
      cmd   = '0;

      // encoder edge filter and saturating step count
      if (enc_age != AGE_MAX) enc_age = enc_age + 1'b1;
      if (a != raw_a && enc_age >= cfg.encoder_debounce_ticks) begin
         enc_age = '0;
         if (a != settled_a) begin
            if (b != a) begin
               if (step_count != STEP_MAX) step_count = step_count + 8'sd1;
            end else if (step_count != STEP_MIN) begin
               step_count = step_count - 8'sd1;
            end
            settled_a = a;
         end
      end
      raw_a = a;

      // button stability timer
      if (button_age != AGE_MAX) button_age = button_age + 1'b1;
      if (button != last_button) begin
         button_age  = '0;
         button_done = 1'b0;
      end
      last_button = button;
      mute_wanted = button_age > cfg.button_debounce_ticks && !button && !button_done;

      // pulse sequencer
      if (phase == PHASE_HOLD) begin
         if (phase_count <= 16'd1) begin
            phase       = PHASE_GAP;
            phase_count = {8'd0, cfg.gap_ticks};
            fired       = 1'b1;
            cmd.wiper   = cfg.idle_position;
            cmd.kind    = KIND_RELEASE;
         end else begin
            phase_count = phase_count - 1'b1;
         end
         return;
      end
      if (phase == PHASE_GAP) begin
         if (phase_count != 0) phase_count = phase_count - 1'b1;
         if (phase_count != 0) return;
         phase = PHASE_IDLE;
      end
      if (step_count != 0) begin
         fired       = 1'b1;
         cmd.wiper   = (step_count > 0) ? cfg.up_position : cfg.down_position;
         cmd.kind    = (step_count > 0) ? KIND_UP : KIND_DOWN;
         step_count  = '0;
         phase       = PHASE_HOLD;
         phase_count = cfg.pulse_ticks;
      end else if (mute_wanted) begin
         fired       = 1'b1;
         cmd.wiper   = cfg.mute_position;
         cmd.kind    = KIND_MUTE;
         button_done = 1'b1;
         phase       = PHASE_HOLD;
         phase_count = cfg.pulse_ticks;
      end
   endfunction

   function automatic void set_register(input logic [CsrIndexWidth-1:0] index,
                                        input logic [CsrDataWidth-1:0] data);
      case (index)
         CSR_PULSE_TICKS:   cfg.pulse_ticks            = data;
         CSR_GAP_TICKS:     cfg.gap_ticks              = data[7:0];
         CSR_ENC_DEBOUNCE:  cfg.encoder_debounce_ticks = data[7:0];
         CSR_BTN_DEBOUNCE:  cfg.button_debounce_ticks  = data[7:0];
         CSR_IDLE_POSITION: cfg.idle_position          = data[7:0];
         CSR_UP_POSITION:   cfg.up_position            = data[7:0];
         CSR_DOWN_POSITION: cfg.down_position          = data[7:0];
         CSR_MUTE_POSITION: cfg.mute_position          = data[7:0];
         default: ;
      endcase
   endfunction

   // stimulus builders, tracking the line levels at the queue tail
   task automatic push_tick(input logic a, input logic b, input logic button);
      tick_sample_type sample;
      sample.a      = a;
      sample.b      = b;
      sample.button = button;
      line_a_now    = a;
      line_b_now    = b;
      button_now    = button;
      tick_queue.push_back(sample);
   endtask

   task automatic push_hold(input int count);
      repeat (count) push_tick(line_a_now, line_b_now, button_now);
   endtask

   // one detent: set B against the coming A level, then move A
   task automatic turn(input logic up, input int dwell);
      push_tick(line_a_now, up ? line_a_now : ~line_a_now, button_now);
      push_hold(dwell - 1);
      push_tick(~line_a_now, line_b_now, button_now);
      push_hold(dwell - 1);
   endtask

   // one A edge in a single tick, B chosen for the direction
   task automatic click(input logic up);
      push_tick(~line_a_now, up ? line_a_now : ~line_a_now, button_now);
   endtask

   task automatic press(input int hold, input int rest);
      push_tick(line_a_now, line_b_now, 1'b0);
      push_hold(hold - 1);
      push_tick(line_a_now, line_b_now, 1'b1);
      push_hold(rest - 1);
   endtask

   // contact chatter on line A, one toggle per tick
   task automatic bounce(input int toggles);
      repeat (toggles) push_tick(~line_a_now, line_b_now, button_now);
   endtask

   // mostly clean detents and presses sized to the debounce settings, some chatter
   task automatic random_ticks(input int count);
      int target;
      int dwell_cap;
      int hold_cap;
      int pick;
      target    = tick_queue.size() + count;
      dwell_cap = (cfg.encoder_debounce_ticks > 4) ? 6 : cfg.encoder_debounce_ticks + 2;
      hold_cap  = (cfg.button_debounce_ticks > 30) ? 34 : cfg.button_debounce_ticks + 4;
      while (tick_queue.size() < target) begin
         pick = $urandom_range(99);
         if (pick < 55) turn(1'($urandom_range(1)), $urandom_range(1, dwell_cap));
         else if (pick < 72) press($urandom_range(1, hold_cap), $urandom_range(1, 3));
         else if (pick < 88) bounce($urandom_range(1, 5));
         else push_tick(1'($urandom_range(1)), 1'($urandom_range(1)),
                        1'($urandom_range(1)));
      end
   endtask

   // write every register back to back; starts and ends on a rising edge
   task automatic write_config(input logic [15:0] pulse, input logic [7:0] gap,
                               input logic [7:0] enc_hold, input logic [7:0] btn_hold,
                               input logic [7:0] idle_pos, input logic [7:0] up_pos,
                               input logic [7:0] down_pos, input logic [7:0] mute_pos);
      logic [CsrDataWidth-1:0] values [8];
      // junk in the upper byte of the narrow registers must be dropped
      values[CSR_PULSE_TICKS]   = pulse;
      values[CSR_GAP_TICKS]     = {8'($urandom), gap};
      values[CSR_ENC_DEBOUNCE]  = {8'($urandom), enc_hold};
      values[CSR_BTN_DEBOUNCE]  = {8'($urandom), btn_hold};
      values[CSR_IDLE_POSITION] = {8'($urandom), idle_pos};
      values[CSR_UP_POSITION]   = {8'($urandom), up_pos};
      values[CSR_DOWN_POSITION] = {8'($urandom), down_pos};
      values[CSR_MUTE_POSITION] = {8'($urandom), mute_pos};
      csr_valid <= 1'b1;
      for (int i = 0; i < 8; i++) begin
         csr_index <= i[CsrIndexWidth-1:0];
         csr_wdata <= values[i];
         do @(posedge clock); while (!csr_ready);
         set_register(i[CsrIndexWidth-1:0], values[i]);
      end
      csr_valid <= 1'b0;
   endtask

   // wait until every tick is taken and every predicted write has arrived
   task automatic drain();
      do @(negedge clock);
      while (tick_queue.size() != 0 || req_valid || expected_writes.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input logic [15:0] pulse, input logic [7:0] gap,
                            input logic [7:0] enc_hold, input logic [7:0] btn_hold,
                            input logic [7:0] idle_pos, input logic [7:0] up_pos,
                            input logic [7:0] down_pos, input logic [7:0] mute_pos,
                            input int count);
      write_config(pulse, gap, enc_hold, btn_hold, idle_pos, up_pos, down_pos, mute_pos);
      @(negedge clock);
      random_ticks(count);
      drain();
   endtask

   // tick driver: offers queued samples, predicts each accepted transfer
   always @(posedge clock) begin : driver
      tick_sample_type pending_tick;
      logic            fired;
      wiper_write_type cmd;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            advance_commander(req_line_a, req_line_b, req_button_level, fired, cmd);
            if (fired) expected_writes.push_back(cmd);
         end
         // a stalled offer keeps its payload
         if (!req_valid || req_ready) begin
            if (tick_queue.size() != 0 && (steady_run || $urandom_range(99) >= IDLE_PERCENT))
            begin
               pending_tick = tick_queue.pop_front();
               req_valid        <= 1'b1;
               req_line_a       <= pending_tick.a;
               req_line_b       <= pending_tick.b;
               req_button_level <= pending_tick.button;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // write monitor: compares each transfer with the oldest prediction
   always @(posedge clock) begin : monitor
      wiper_write_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_writes.size() == 0) begin
               error_count++;
               $display("%0t: unexpected write, expected none, actual value %0d kind %0d",
                        $time, rsp_wiper_value, rsp_command_kind);
            end else begin
               want = expected_writes.pop_front();
               if (rsp_wiper_value !== want.wiper) begin
                  error_count++;
                  $display("%0t: wiper_value expected %0d actual %0d",
                           $time, want.wiper, rsp_wiper_value);
               end
               if (rsp_command_kind !== want.kind) begin
                  error_count++;
                  $display("%0t: command_kind expected %0d actual %0d",
                           $time, want.kind, rsp_command_kind);
               end
            end
            // one long hold-off so the block backs up into its input
            if (steady_run && !stall_done) begin
               stall_left = STALL_CYCLES;
               stall_done = 1'b1;
            end
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= steady_run || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("tb_encoder_button_pulse_commander: done, errors");
         $finish;
      end
   end

   initial begin : stimulus
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: both turn directions, press, press while busy, zero gap
      write_config(16'd2, 8'd0, 8'd0, 8'd1, 8'd255, 8'd0, 8'd255, 8'd128);
      @(negedge clock);
      turn(1'b1, 1);
      turn(1'b0, 1);
      push_hold(3);
      press(3, 1);
      // encoder step wins over a waiting mute, which is retried later
      turn(1'b1, 1);
      press(4, 1);
      push_tick(~line_a_now, ~line_b_now, line_b_now);
      push_tick(~line_a_now, ~line_b_now, ~button_now);
      push_hold(4);
      drain();

      // shortest pulse with zero gap, then zero pulse, then a long gap
      run_phase(16'd1, 8'd0, 8'd2, 8'd3, 8'($urandom), 8'($urandom), 8'($urandom),
                8'($urandom), 14);
      run_phase(16'd0, 8'd1, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255, 14);
      run_phase(16'd3, 8'd12, 8'd1, 8'd2, 8'($urandom), 8'($urandom), 8'($urandom),
                8'($urandom), 14);
      // longest debounce on both inputs: mostly filtered away
      run_phase(16'd2, 8'd2, 8'd255, 8'd255, 8'($urandom), 8'($urandom), 8'($urandom),
                8'($urandom), 14);

      // no idling on either side, with one long receiver hold-off
      write_config(16'd1, 8'd1, 8'd0, 8'd0, 8'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom));
      @(negedge clock);
      steady_run = 1'b1;
      random_ticks(36);
      // let the sequencer fall idle with the button released
      push_tick(line_a_now, line_b_now, 1'b1);
      push_hold(8);
      drain();
      @(negedge clock);
      steady_run = 1'b0;
      @(posedge clock);

      // step count clamps at both ends during long pulses; button held low
      // the whole time never acts with the longest button debounce
      write_config(16'd130, 8'd1, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd128);
      @(negedge clock);
      push_tick(line_a_now, line_b_now, 1'b0);
      repeat (130) click(1'b1);
      push_hold(2);
      repeat (130) click(1'b0);
      drain();
      // short pulse so the clamped down count comes out promptly
      write_config(16'd1, 8'd1, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd128);
      @(negedge clock);
      push_hold(1);
      push_tick(line_a_now, line_b_now, 1'b1);
      push_hold(2);
      drain();

      // random settings
      run_phase(16'($urandom_range(1, 6)), 8'($urandom_range(0, 4)),
                8'($urandom_range(0, 3)), 8'($urandom_range(0, 5)), 8'($urandom),
                8'($urandom), 8'($urandom), 8'($urandom), 16);

      // longest pulse: one command whose release lies beyond the run
      write_config(16'hffff, 8'd255, 8'd0, 8'd0, 8'($urandom), 8'($urandom),
                   8'($urandom), 8'($urandom));
      @(negedge clock);
      turn(1'b0, 1);
      push_hold(5);
      press(3, 3);
      push_hold(10);
      drain();

      if (error_count == 0 && expected_writes.size() == 0)
         $display("tb_encoder_button_pulse_commander: done, clean");
      else
         $display("tb_encoder_button_pulse_commander: done, errors");
      $finish;
   end

endmodule
